### hw/rtl/cpg_pkg.sv
package cpg_pkg;

	localparam int CORDIC_ITERS = 24;
	localparam int ITER_W = $clog2(CORDIC_ITERS);

	localparam int XY_W = 36;
	localparam int Z_W = 34;
	localparam int ZIN_W = 39;
	localparam int RED_STEPS = 6;

	localparam int DIGIT_W = 4;
	localparam int MUL_AW = XY_W;
	localparam int MUL_BW = 32;
	localparam int MUL_DIGITS = MUL_BW / DIGIT_W;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_STEP_SIZE = 1'b1;

	localparam logic [ZIN_W-1:0] TWO_PI_ZIN = ZIN_W'(64'd6746518852);
	localparam logic signed [Z_W-1:0] TWO_PI_Q30 = Z_W'(64'd6746518852);
	localparam logic signed [Z_W-1:0] PI_Q30 = Z_W'(64'd3373259426);
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'd1686629713);
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/cpg_mul.sv
module cpg_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [cpg_pkg::MUL_AW-1:0]    a,
	input  logic        [cpg_pkg::MUL_BW-1:0]    b,
	output logic                                 done,
	output logic signed [cpg_pkg::MUL_PW-1:0]    prod
);

	localparam int AW = cpg_pkg::MUL_AW;
	localparam int BW = cpg_pkg::MUL_BW;
	localparam int DW = cpg_pkg::DIGIT_W;
	localparam int CNT_W = $clog2(cpg_pkg::MUL_DIGITS);
	localparam int SUM_W = AW + DW + 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(cpg_pkg::MUL_DIGITS - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [AW-1:0]    a_q;
	logic signed [AW-1:0]    hi_q;
	logic [BW-1:0]           b_q;
	logic [BW-1:0]           lo_q;
	logic signed [DW:0]      digit;
	logic signed [SUM_W-1:0] pp;
	logic signed [SUM_W-1:0] sum;

	// One multiplier digit per cycle; the partial sum shifts right into lo_q.
	assign digit = $signed({1'b0, b_q[DW-1:0]});
	assign pp = SUM_W'(a_q) * SUM_W'(digit);
	assign sum = SUM_W'(hi_q) + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[AW+DW-1:DW];
			lo_q <= {sum[DW-1:0], lo_q[BW-1:DW]};
			b_q <= b_q >> DW;
		end
	end

	assign done = done_q;
	assign prod = $signed({hi_q, lo_q});

endmodule

### hw/rtl/cpg_cordic.sv
module cpg_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic        [cpg_pkg::ZIN_W-1:0]   z_in,
	input  logic signed [31:0]                 x_in,
	input  logic signed [31:0]                 y_in,
	output logic                               done,
	output logic signed [cpg_pkg::XY_W-1:0]    x_out,
	output logic signed [cpg_pkg::XY_W-1:0]    y_out
);

	localparam int XW = cpg_pkg::XY_W;
	localparam int ZW = cpg_pkg::Z_W;
	localparam int ZIW = cpg_pkg::ZIN_W;
	localparam int RED_W = $clog2(cpg_pkg::RED_STEPS);
	localparam int IT_W = cpg_pkg::ITER_W;
	localparam logic [RED_W-1:0] RED_LAST = RED_W'(cpg_pkg::RED_STEPS - 1);
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(cpg_pkg::CORDIC_ITERS - 1);

	typedef enum logic [1:0] {
		C_IDLE,
		C_REDUCE,
		C_FOLD,
		C_ITER
	} state_t;

	state_t               state_q;
	logic [RED_W-1:0]     red_q;
	logic [IT_W-1:0]      it_q;
	logic                 done_q;
	logic [ZIW-1:0]       zr_q;
	logic [ZIW-1:0]       div_q;
	logic signed [ZW-1:0] za_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;

	logic signed [ZW-1:0] zw;
	logic signed [ZW-1:0] zf;
	logic                 flip;
	logic signed [ZW-1:0] atan;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	// Fold the reduced angle into [-pi/2, pi/2], turning the vector by pi if needed.
	always_comb begin
		if ($signed(zr_q[ZW-1:0]) >= cpg_pkg::PI_Q30) begin
			zw = $signed(zr_q[ZW-1:0]) - cpg_pkg::TWO_PI_Q30;
		end else begin
			zw = $signed(zr_q[ZW-1:0]);
		end
		if (zw > cpg_pkg::HALF_PI_Q30) begin
			flip = 1'b1;
			zf = zw - cpg_pkg::PI_Q30;
		end else if (zw < -cpg_pkg::HALF_PI_Q30) begin
			flip = 1'b1;
			zf = zw + cpg_pkg::PI_Q30;
		end else begin
			flip = 1'b0;
			zf = zw;
		end
	end

	assign atan = $signed(ZW'(cpg_pkg::atan_q30(5'(it_q))));
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			red_q <= '0;
			it_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == C_ITER) && (it_q == IT_LAST);
			case (state_q)
				C_IDLE: begin
					if (start) begin
						red_q <= '0;
						state_q <= C_REDUCE;
					end
				end
				C_REDUCE: begin
					red_q <= red_q + 1'b1;
					if (red_q == RED_LAST) begin
						state_q <= C_FOLD;
					end
				end
				C_FOLD: begin
					it_q <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_LAST) begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					zr_q <= z_in;
					div_q <= cpg_pkg::TWO_PI_ZIN << (cpg_pkg::RED_STEPS - 1);
					x_q <= XW'(x_in);
					y_q <= XW'(y_in);
				end
			end
			C_REDUCE: begin
				if (zr_q >= div_q) begin
					zr_q <= zr_q - div_q;
				end
				div_q <= div_q >> 1;
			end
			C_FOLD: begin
				za_q <= zf;
				if (flip) begin
					x_q <= -x_q;
					y_q <= -y_q;
				end
			end
			C_ITER: begin
				if (!za_q[ZW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					za_q <= za_q - atan;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					za_q <= za_q + atan;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign x_out = x_q;
	assign y_out = y_q;

endmodule

### hw/rtl/clothoid_point_generator.sv
// Clothoid point generator: walks an Euler spiral one step per input word.
// Input stream: each accepted word carries restart in tdata bit 0. A restart
// word returns the origin and resets the tangent, arc length and index; any
// other word advances one step and returns the new point with its mirror.
// Once point_count steps have been taken, advance words repeat the last point
// with the done flag set in tuser.
// Configuration: a write on cfg_valid/cfg_ready with cfg_index 0 sets
// point_count, index 1 sets step_size; write only while the block is idle.
// Flow: a restart or repeat word goes from idle through the emit state into
// the output register. An advance word runs three 4-bit-digit serial
// multiplies (position, angle, gain) and a CORDIC pass of angle reduction,
// fold and rotation steps, then goes through the emit state as well.
// One word is worked on at a time; the next word is taken only back in idle.
// The result sits in an output register; the next input word is taken while
// it waits, and the engine holds its finished result until the register
// drains, so a stalled receiver just stalls the input side.
// Reset clears the point state to the origin with tangent (1, 0) and loads
// point_count 5000 and step_size 83886.
module clothoid_point_generator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [0] restart, [7:1] zero
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,   // pos_x, pos_y, mirror_x, mirror_y, point_index
	output logic [1:0]   m_axis_tuser,   // [0] mirror_valid, [1] done_res
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [23:0]  cfg_data
);

	localparam int AW = cpg_pkg::MUL_AW;
	localparam int BW = cpg_pkg::MUL_BW;
	localparam int PW = cpg_pkg::MUL_PW;
	localparam int XW = cpg_pkg::XY_W;
	localparam int SAT_W = 40;
	localparam int ARC_PW = 56;

	localparam logic signed [31:0] ONE_Q29 = 32'sd536870912;
	localparam logic [15:0] POINT_COUNT_RST = 16'd5000;
	localparam logic [23:0] STEP_SIZE_RST = 24'd83886;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POS,
		S_ARC,
		S_ROT,
		S_GAIN,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic signed [31:0]    cur_x_q;
	logic signed [31:0]    cur_y_q;
	logic signed [31:0]    dir_x_q;
	logic signed [31:0]    dir_y_q;
	logic [31:0]           arc_q;
	logic [15:0]           steps_q;
	logic                  done_flag_q;
	logic [15:0]           point_count_q;
	logic [23:0]           step_size_q;
	logic                  mul_start_q;
	logic                  rot_start_q;
	logic signed [AW-1:0]  opa_x_q;
	logic signed [AW-1:0]  opa_y_q;
	logic [BW-1:0]         opb_q;
	logic                  out_valid_q;
	logic [143:0]          out_data_q;
	logic [1:0]            out_user_q;

	logic                  mul_done_x;
	logic                  mul_done_y;
	logic signed [PW-1:0]  prod_x;
	logic signed [PW-1:0]  prod_y;
	logic                  rot_done;
	logic signed [XW-1:0]  rot_x;
	logic signed [XW-1:0]  rot_y;

	logic signed [PW-1:0]  pos_rnd_x;
	logic signed [PW-1:0]  pos_rnd_y;
	logic signed [PW-25:0] delta_x;
	logic signed [PW-25:0] delta_y;
	logic signed [SAT_W-1:0] pos_sum_x;
	logic signed [SAT_W-1:0] pos_sum_y;
	logic [32:0]           arc_wide;
	logic [31:0]           arc_next;
	logic [ARC_PW:0]       z_rnd;
	logic signed [PW-1:0]  gain_rnd_x;
	logic signed [PW-1:0]  gain_rnd_y;
	logic signed [PW-31:0] gain_x;
	logic signed [PW-31:0] gain_y;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v > $signed(SAT_W'(32'h7FFFFFFF))) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_W'(32'sh80000000)) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] neg32(input logic signed [31:0] v);
		logic [31:0] r;
		if (v == 32'sh80000000) begin
			r = 32'h7FFFFFFF;
		end else begin
			r = -v;
		end
		return r;
	endfunction

	assign pos_rnd_x = prod_x + PW'(1 << 23);
	assign pos_rnd_y = prod_y + PW'(1 << 23);
	assign delta_x = pos_rnd_x[PW-1:24];
	assign delta_y = pos_rnd_y[PW-1:24];
	assign pos_sum_x = SAT_W'(cur_x_q) + SAT_W'(delta_x);
	assign pos_sum_y = SAT_W'(cur_y_q) + SAT_W'(delta_y);

	assign arc_wide = {1'b0, arc_q} + 33'(step_size_q);
	assign arc_next = arc_wide[32] ? 32'hFFFFFFFF : arc_wide[31:0];

	assign z_rnd = (ARC_PW + 1)'(prod_x[ARC_PW-1:0]) + (ARC_PW + 1)'(1 << 17);

	assign gain_rnd_x = prod_x + PW'(1 << 29);
	assign gain_rnd_y = prod_y + PW'(1 << 29);
	assign gain_x = gain_rnd_x[PW-1:30];
	assign gain_y = gain_rnd_y[PW-1:30];

	cpg_mul u_mul_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (opa_x_q),
		.b      (opb_q),
		.done   (mul_done_x),
		.prod   (prod_x)
	);

	cpg_mul u_mul_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (opa_y_q),
		.b      (opb_q),
		.done   (mul_done_y),
		.prod   (prod_y)
	);

	cpg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start_q),
		.z_in   (z_rnd[ARC_PW:18]),
		.x_in   (dir_x_q),
		.y_in   (dir_y_q),
		.done   (rot_done),
		.x_out  (rot_x),
		.y_out  (rot_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			dir_x_q <= ONE_Q29;
			dir_y_q <= '0;
			arc_q <= '0;
			steps_q <= '0;
			done_flag_q <= 1'b0;
			point_count_q <= POINT_COUNT_RST;
			step_size_q <= STEP_SIZE_RST;
			mul_start_q <= 1'b0;
			rot_start_q <= 1'b0;
			opa_x_q <= '0;
			opa_y_q <= '0;
			opb_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			out_user_q <= '0;
		end else begin
			mul_start_q <= ((state_q == S_IDLE) && s_axis_tvalid && !s_axis_tdata[0]
				&& (steps_q < point_count_q))
				|| ((state_q == S_POS) && mul_done_x)
				|| ((state_q == S_ROT) && rot_done);
			rot_start_q <= (state_q == S_ARC) && mul_done_x;
			if (out_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					cpg_pkg::REG_POINT_COUNT: point_count_q <= cfg_data[15:0];
					cpg_pkg::REG_STEP_SIZE: step_size_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tdata[0]) begin
							cur_x_q <= '0;
							cur_y_q <= '0;
							dir_x_q <= ONE_Q29;
							dir_y_q <= '0;
							arc_q <= '0;
							steps_q <= '0;
							done_flag_q <= 1'b0;
							state_q <= S_EMIT;
						end else if (steps_q >= point_count_q) begin
							done_flag_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							done_flag_q <= 1'b0;
							opa_x_q <= AW'(dir_x_q);
							opa_y_q <= AW'(dir_y_q);
							opb_q <= BW'(step_size_q);
							state_q <= S_POS;
						end
					end
				end
				S_POS: begin
					if (mul_done_x) begin
						cur_x_q <= sat32(pos_sum_x);
						cur_y_q <= sat32(pos_sum_y);
						arc_q <= arc_next;
						opa_x_q <= AW'(arc_next);
						opa_y_q <= AW'(arc_next);
						state_q <= S_ARC;
					end
				end
				S_ARC: begin
					if (mul_done_x) begin
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (rot_done) begin
						opa_x_q <= rot_x;
						opa_y_q <= rot_y;
						opb_q <= BW'(cpg_pkg::GAIN_Q30);
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					if (mul_done_x) begin
						dir_x_q <= sat32(SAT_W'(gain_x));
						dir_y_q <= sat32(SAT_W'(gain_y));
						steps_q <= steps_q + 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q <= {steps_q, neg32(cur_y_q), neg32(cur_x_q),
							cur_y_q, cur_x_q};
						out_user_q <= {done_flag_q, steps_q != 16'd0};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;
	assign cfg_ready = 1'b1;

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_x == mul_done_y)
		else $error("Multiplier lanes have lost step.");

	a_mul_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_x |-> (state_q == S_POS || state_q == S_ARC || state_q == S_GAIN))
		else $error("Multiplier finished outside a multiply phase.");

	a_rot_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rot_done |-> state_q == S_ROT)
		else $error("Rotation finished outside the rotation phase.");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("A result word appeared without an emit cycle.");

endmodule

### tb/sv/tb_clothoid_point_generator.sv
`timescale 1ns / 100ps

module tb_clothoid_point_generator;

	localparam int INT_HI = 32'sh7FFFFFFF;
	localparam int INT_LO = 32'sh80000000;
	localparam int ONE_Q29 = 32'sh20000000;
	localparam longint ANGLE_PI = 64'sd3373259426;
	localparam longint ANGLE_TWO_PI = 64'sd6746518852;
	localparam longint ANGLE_HALF_PI = 64'sd1686629713;
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam longint ROUND24 = 64'sd8388608;
	localparam longint ROUND30 = 64'sd536870912;
	localparam longint ARCTAN_Q30 [0:31] = '{
		64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
		64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
		64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
		64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
		64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F, 64'sh0000003F,
		64'sh0000001F, 64'sh0000000F, 64'sh00000008, 64'sh00000004, 64'sh00000002,
		64'sh00000001, 64'sh00000000
	};

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] mirror_x;
		logic signed [31:0] mirror_y;
		logic               mirror_valid;
		logic [15:0]        point_index;
		logic               done;
	} spiral_point_t;

	class clothoid_walk;
		logic [15:0] point_count;
		logic [23:0] step_size;
		int cur_x, cur_y, dir_x, dir_y;
		int unsigned arc_length;
		logic [15:0] steps_done;
		spiral_point_t pending_points[$];
		int mismatches;

		function new();
			point_count = 16'd5000;
			step_size = 24'd83886;
			mismatches = 0;
			home();
		endfunction

		function void home();
			cur_x = 0;
			cur_y = 0;
			dir_x = ONE_Q29;
			dir_y = 0;
			arc_length = 0;
			steps_done = 16'd0;
		endfunction

		function void write_reg(bit index, logic [23:0] value);
			if (index == cpg_pkg::REG_POINT_COUNT) begin
				point_count = value[15:0];
			end else begin
				step_size = value;
			end
		endfunction

		function int clamp32(longint v);
			if (v > longint'(INT_HI))
				return INT_HI;
			if (v < longint'(INT_LO))
				return INT_LO;
			return int'(v);
		endfunction

		function void take_word(bit restart);
			spiral_point_t p;
			longint s, x, y, z, dx, dy;
			logic [63:0] sum, prod;
			p.done = 1'b0;
			if (restart) begin
				home();
			end else if (steps_done >= point_count) begin
				p.done = 1'b1;
			end else begin
				s = longint'(step_size);
				cur_x = clamp32(longint'(cur_x) + ((longint'(dir_x) * s + ROUND24) >>> 24));
				cur_y = clamp32(longint'(cur_y) + ((longint'(dir_y) * s + ROUND24) >>> 24));
				sum = 64'(arc_length) + 64'(step_size);
				arc_length = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
				prod = 64'(arc_length) * 64'(step_size);
				z = longint'((prod + 64'd131072) >> 18);
				z = z % ANGLE_TWO_PI;
				if (z >= ANGLE_PI)
					z -= ANGLE_TWO_PI;
				x = longint'(dir_x);
				y = longint'(dir_y);
				if (z > ANGLE_HALF_PI) begin
					x = -x;
					y = -y;
					z -= ANGLE_PI;
				end else if (z < -ANGLE_HALF_PI) begin
					x = -x;
					y = -y;
					z += ANGLE_PI;
				end
				for (int i = 0; i < cpg_pkg::CORDIC_ITERS && i < 32; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (z >= 0) begin
						x -= dx;
						y += dy;
						z -= ARCTAN_Q30[i];
					end else begin
						x += dx;
						y -= dy;
						z += ARCTAN_Q30[i];
					end
				end
				dir_x = clamp32((x * CORDIC_GAIN + ROUND30) >>> 30);
				dir_y = clamp32((y * CORDIC_GAIN + ROUND30) >>> 30);
				steps_done = steps_done + 16'd1;
			end
			p.pos_x = cur_x;
			p.pos_y = cur_y;
			p.mirror_x = clamp32(-longint'(cur_x));
			p.mirror_y = clamp32(-longint'(cur_y));
			p.mirror_valid = (steps_done != 16'd0);
			p.point_index = steps_done;
			pending_points = {pending_points, p};
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s expected %h actual %h", $time, field, want, got);
			end
		endfunction

		function void check_point(logic [143:0] data, logic [1:0] user);
			spiral_point_t want;
			if (pending_points.size() == 0) begin
				mismatches++;
				$display("%0t: point expected none actual %h %h", $time, data, user);
				return;
			end
			want = pending_points.pop_front();
			compare("pos_x", want.pos_x, data[31:0]);
			compare("pos_y", want.pos_y, data[63:32]);
			compare("mirror_x", want.mirror_x, data[95:64]);
			compare("mirror_y", want.mirror_y, data[127:96]);
			compare("point_index", 32'(want.point_index), 32'(data[143:128]));
			compare("mirror_valid", 32'(want.mirror_valid), 32'(user[0]));
			compare("done_res", 32'(want.done), 32'(user[1]));
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [23:0]  cfg_data;

	clothoid_walk walk;
	bit no_gaps;
	int words_sent;

	clothoid_point_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 6);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			walk.check_point(m_axis_tdata, m_axis_tuser);
	end

	task automatic set_reg(input bit index, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		walk.write_reg(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(input bit restart);
		while (!no_gaps && $urandom_range(0, 99) < 6) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, restart};
		do @(posedge clk); while (!s_axis_tready);
		walk.take_word(restart);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (walk.pending_points.size() != 0)
			@(negedge clk);
	endtask

	task automatic walk_curve(input int words);
		for (int n = 0; n < words; n++)
			send_word(n == 0 ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 3));
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cpg_pkg::REG_POINT_COUNT;
		cfg_data = 24'd0;
		no_gaps = 1'b0;
		words_sent = 0;
		walk = new();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		send_word(1'b0);
		send_word(1'b0);
		send_word(1'b1);
		drain();
		set_reg(cpg_pkg::REG_POINT_COUNT, 24'd0);
		send_word(1'b0);
		send_word(1'b0);
		send_word(1'b1);
		drain();
		set_reg(cpg_pkg::REG_POINT_COUNT, 24'd2);
		set_reg(cpg_pkg::REG_STEP_SIZE, 24'd0);
		send_word(1'b0);
		send_word(1'b0);
		send_word(1'b0);
		drain();
		set_reg(cpg_pkg::REG_POINT_COUNT, 24'd3);
		set_reg(cpg_pkg::REG_STEP_SIZE, 24'hFFFFFF);
		send_word(1'b1);
		repeat (4) send_word(1'b0);
		drain();
		set_reg(cpg_pkg::REG_POINT_COUNT, 24'd65535);
		set_reg(cpg_pkg::REG_STEP_SIZE, 24'd1);
		send_word(1'b1);
		repeat (3) send_word(1'b0);

		drain();
		no_gaps = 1'b1;
		set_reg(cpg_pkg::REG_POINT_COUNT, 24'd400);
		set_reg(cpg_pkg::REG_STEP_SIZE, 24'hFFFFFF);
		send_word(1'b1);
		repeat (300) send_word(1'b0);
		drain();
		no_gaps = 1'b0;

		while (words_sent < 1500) begin
			drain();
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 6))
					0: set_reg(cpg_pkg::REG_POINT_COUNT, 24'd1);
					1: set_reg(cpg_pkg::REG_POINT_COUNT, 24'($urandom_range(2, 20)));
					2: set_reg(cpg_pkg::REG_POINT_COUNT, 24'($urandom_range(20, 200)));
					3: set_reg(cpg_pkg::REG_POINT_COUNT, 24'd65535);
					4: set_reg(cpg_pkg::REG_POINT_COUNT, 24'd0);
					default: set_reg(cpg_pkg::REG_POINT_COUNT,
						24'($urandom_range(1, 65535)));
				endcase
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 6))
					0: set_reg(cpg_pkg::REG_STEP_SIZE, 24'd1);
					1: set_reg(cpg_pkg::REG_STEP_SIZE, 24'hFFFFFF);
					2: set_reg(cpg_pkg::REG_STEP_SIZE, 24'd83886);
					3: set_reg(cpg_pkg::REG_STEP_SIZE, 24'($urandom_range(1, 200000)));
					4: set_reg(cpg_pkg::REG_STEP_SIZE, 24'd0);
					default: set_reg(cpg_pkg::REG_STEP_SIZE,
						24'($urandom_range(1, 16777215)));
				endcase
			end
			walk_curve($urandom_range(10, 120));
		end

		drain();
		repeat (100) @(posedge clk);
		if (walk.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
